@@ hw/rtl/chf_pkg.sv @@
// Shared types and constants of the circular handle FIFO.
package chf_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic exec;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic remain_zero;
    } t_status;

    localparam logic [4:0] CAP_RESET   = 5'd16;
    localparam int         CAP_W       = 5;
    localparam int         FILL_W      = 5;
    localparam logic [0:0] REG_CAPACITY = 1'b0;

endpackage

@@ hw/rtl/chf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module chf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/chf_ctrl.sv @@
// Controller state machine that sequences push, pop, peek and flush.
module chf_ctrl
    import chf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_op     i_op,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    // Pop, peek and flush on a non-empty queue go through a store read first; the rest go to execute.
                    if (i_op == OP_PUSH || i_status.empty) begin
                        n_state = ST_EXEC;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_OUT;
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = i_status.remain_zero ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/chf_datapath.sv @@
// Datapath: indices, capacity, handle store, flush walker and result register.
module chf_datapath
    import chf_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  t_op                     i_op,
    input  logic [HANDLE_WIDTH-1:0] i_handle,
    input  logic                    i_cfg_we,
    input  logic [CAP_W-1:0]        i_cfg_data,
    output logic [CAP_W-1:0]        o_cap,
    output logic [HANDLE_WIDTH-1:0] o_handle,
    output logic                    o_handle_valid,
    output logic                    o_accepted,
    output logic [FILL_W-1:0]       o_fill,
    output logic                    o_queue_empty,
    output logic                    o_last
);

    localparam int IW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int CAP_RST = (int'(CAP_RESET) > DEPTH) ? DEPTH : int'(CAP_RESET);

    function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx,
                                          input logic [CW-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc < cap) ? IW'(inc) : '0;
    endfunction

    function automatic logic [CW-1:0] fill(input logic [IW-1:0] old,
                                           input logic [IW-1:0] nf,
                                           input logic          emp,
                                           input logic [CW-1:0] cap);
        logic [CW-1:0] res;
        if (emp) begin
            res = '0;
        end else if (old < nf) begin
            res = CW'(nf) - CW'(old);
        end else begin
            res = cap - (CW'(old) - CW'(nf));
        end
        return res;
    endfunction

    logic [CAP_W-1:0]        r_cap,      n_cap;
    logic [CW-1:0]           r_cap_use,  n_cap_use;
    logic [IW-1:0]           r_oldest,   n_oldest;
    logic [IW-1:0]           r_nf,       n_nf;
    logic                    r_empty,    n_empty;
    logic [IW-1:0]           r_walk,     n_walk;
    logic [CW-1:0]           r_remain,   n_remain;
    t_op                     r_op,       n_op;
    logic [HANDLE_WIDTH-1:0] r_handle,   n_handle;

    logic [HANDLE_WIDTH-1:0] r_out_handle, n_out_handle;
    logic                    r_out_valid,  n_out_valid;
    logic                    r_out_acc,    n_out_acc;
    logic [CW-1:0]           r_out_fill;
    logic                    r_out_empty;
    logic                    r_out_last,   n_out_last;
    logic                    ld_out;

    logic                    we;
    logic [IW-1:0]           waddr;
    logic [HANDLE_WIDTH-1:0] rdata;
    logic [IW-1:0]           adv_old;

    chf_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_handle),
        .i_raddr (r_walk),
        .o_rdata (rdata)
    );

    assign adv_old = adv(r_oldest, r_cap_use);

    always_comb begin
        n_cap        = r_cap;
        n_cap_use    = r_cap_use;
        n_oldest     = r_oldest;
        n_nf         = r_nf;
        n_empty      = r_empty;
        n_walk       = r_walk;
        n_remain     = r_remain;
        n_op         = r_op;
        n_handle     = r_handle;
        n_out_handle = '0;
        n_out_valid  = 1'b0;
        n_out_acc    = 1'b0;
        n_out_last   = 1'b1;
        ld_out       = 1'b0;
        we           = 1'b0;
        waddr        = r_nf;
        if (i_cfg_we) begin
            n_cap    = i_cfg_data;
            n_oldest = '0;
            n_nf     = '0;
            n_empty  = 1'b1;
            // A capacity of zero acts as one, anything above the store depth as the depth.
            if (i_cfg_data == '0) begin
                n_cap_use = CW'(1);
            end else if (32'(i_cfg_data) > 32'(DEPTH)) begin
                n_cap_use = CW'(DEPTH);
            end else begin
                n_cap_use = CW'(i_cfg_data);
            end
        end else if (i_cmd.start) begin
            n_op     = i_op;
            n_handle = i_handle;
            n_walk   = r_oldest;
            if (i_op == OP_FLUSH) begin
                n_remain = fill(r_oldest, r_nf, r_empty, r_cap_use);
                n_empty  = 1'b1;
            end else begin
                n_remain = '0;
            end
        end else if (i_cmd.exec) begin
            ld_out = 1'b1;
            if (r_op == OP_PUSH) begin
                if (r_empty) begin
                    // A push into an empty queue restarts both indices.
                    we        = 1'b1;
                    waddr     = '0;
                    n_oldest  = '0;
                    n_nf      = adv('0, r_cap_use);
                    n_empty   = 1'b0;
                    n_out_acc = 1'b1;
                end else if (r_nf != r_oldest) begin
                    we        = 1'b1;
                    n_nf      = adv(r_nf, r_cap_use);
                    n_out_acc = 1'b1;
                end
            end
        end else if (i_cmd.load) begin
            ld_out       = 1'b1;
            n_out_handle = rdata;
            n_out_valid  = 1'b1;
            n_out_acc    = 1'b1;
            if (r_op == OP_FLUSH) begin
                n_out_last = (r_remain == CW'(1));
                n_remain   = r_remain - CW'(1);
                n_walk     = adv(r_walk, r_cap_use);
            end else if (r_op == OP_POP) begin
                n_oldest = adv_old;
                n_empty  = (adv_old == r_nf);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_cap_use <= CW'(CAP_RST);
            r_oldest  <= '0;
            r_nf      <= '0;
            r_empty   <= 1'b1;
            r_remain  <= '0;
        end else begin
            r_cap     <= n_cap;
            r_cap_use <= n_cap_use;
            r_oldest  <= n_oldest;
            r_nf      <= n_nf;
            r_empty   <= n_empty;
            r_remain  <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk   <= n_walk;
        r_op     <= n_op;
        r_handle <= n_handle;
        if (ld_out) begin
            r_out_handle <= n_out_handle;
            r_out_valid  <= n_out_valid;
            r_out_acc    <= n_out_acc;
            r_out_fill   <= fill(n_oldest, n_nf, n_empty, r_cap_use);
            r_out_empty  <= n_empty;
            r_out_last   <= n_out_last;
        end
    end

    assign o_status.empty       = r_empty;
    assign o_status.remain_zero = (r_remain == '0);
    assign o_cap                = r_cap;
    assign o_handle             = r_out_handle;
    assign o_handle_valid       = r_out_valid;
    assign o_accepted           = r_out_acc;
    assign o_fill               = FILL_W'(r_out_fill);
    assign o_queue_empty        = r_out_empty;
    assign o_last               = r_out_last;

endmodule

@@ hw/rtl/circular_handle_fifo.sv @@
// Push, pop, peek: the result is registered; push and empty-queue ops go through the execute state,
// pop and peek through a registered read of the handle store and a load. One word is in flight at
// a time; a flush of n handles gives n results, and the next word waits until the last one is taken.
// Each flush result costs a store read, a load into the result register and the handshake.
// Reset (synchronous, active low) empties the queue and sets the capacity to 16;
// the handle store itself is not cleared.
module circular_handle_fifo
    import chf_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: handle_in
    input  logic [((HANDLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: operation
    input  logic [1:0]                               s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // tdata: handle_out, accepted, fill_count, queue_empty, zero padding
    output logic [((HANDLE_WIDTH + 14) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: handle_valid
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [2:0]                               paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    localparam int OUT_W = ((HANDLE_WIDTH + 14) / 8) * 8;
    localparam int PAD_W = OUT_W - HANDLE_WIDTH - FILL_W - 2;

    t_cmd                    cmd;
    t_status                 status;
    t_op                     op;
    logic                    cfg_we;
    logic [CAP_W-1:0]        cap;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic                    out_acc;
    logic [FILL_W-1:0]       out_fill;
    logic                    out_empty;

    assign op     = t_op'(s_axis_tuser);
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap) : '0;

    chf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (op),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    chf_datapath #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_op           (op),
        .i_handle       (s_axis_tdata[HANDLE_WIDTH-1:0]),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (pwdata[CAP_W-1:0]),
        .o_cap          (cap),
        .o_handle       (out_handle),
        .o_handle_valid (m_axis_tuser),
        .o_accepted     (out_acc),
        .o_fill         (out_fill),
        .o_queue_empty  (out_empty),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_empty, out_fill, out_acc, out_handle};

    // No new word is taken while a result is still pending.
    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while a result is pending");

    a_empty_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_empty == (out_fill == '0)))
        else $error("queue_empty disagrees with fill_count");

    a_invalid_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("result without a handle is not marked last");

    a_flush_reports_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (out_empty && m_axis_tuser))
        else $error("intermediate flush result has wrong status");

endmodule
